// ===== hw/rtl/lsht_pkg.sv =====
// ----------------------------------------------------------------------------
// lsht_pkg - shared types and constants of the symbol hash table
// Item layouts, action and kind codes, name and hash helpers.
// ----------------------------------------------------------------------------
package lsht_pkg;

  localparam int SLOT_W_MAX  = 12;  // enough for the largest slot table
  localparam int HASH_W      = 15;
  localparam int RECIP_SHIFT = 30;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REQ_SYMBOL     = 1'b0;
  localparam logic REQ_MEMBER_END = 1'b1;

  localparam logic [2:0] KIND_UNDEF = 3'd0;
  localparam logic [2:0] KIND_ABS   = 3'd1;
  localparam logic [2:0] KIND_TEXT  = 3'd2;
  localparam logic [2:0] KIND_BSS   = 3'd4;

  typedef enum logic [2:0] {
    ACT_INSERTED     = 3'd0,
    ACT_KEPT         = 3'd1,
    ACT_COMMON       = 3'd2,
    ACT_TEXT_IGNORED = 3'd3,
    ACT_DEFINED      = 3'd4
  } action_t;

  typedef struct packed {
    logic                  req_type;
    logic [63:0]           key;
    logic [SLOT_W_MAX-1:0] home;
    logic [2:0]            kind;
    logic [15:0]           value;
    logic                  is_library;
  } work_t;

  typedef struct packed {
    logic [63:0] name;
    logic [2:0]  kind;
    logic [15:0] value;
  } sym_entry_t;

  typedef struct packed {
    logic clear_done;
  } status_t;

  // Keep bytes up to the first zero byte, clear the rest.
  function automatic logic [63:0] canon_name(input logic [63:0] raw);
    logic [63:0] res;
    logic        live;
    res  = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

  // Shift-and-add over signed bytes; only the low bits survive the mask.
  function automatic logic [HASH_W-1:0] name_hash(input logic [63:0] raw);
    logic [HASH_W-1:0] h;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      h = {h[HASH_W-2:0], 1'b0} + {{(HASH_W-8){raw[8*i+7]}}, raw[8*i +: 8]};
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/lsht_if.sv =====
// ----------------------------------------------------------------------------
// lsht_in_if / lsht_out_if - item channels of the symbol hash table
// Valid/ready channels carrying symbol requests and their results.
// ----------------------------------------------------------------------------
interface lsht_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] sym_name;
  logic [2:0]  sym_kind;
  logic [15:0] sym_value;
  logic        is_library;

  modport source (output valid, req_type, sym_name, sym_kind, sym_value, is_library,
                  input ready);
  modport sink   (input valid, req_type, sym_name, sym_kind, sym_value, is_library,
                  output ready);
endinterface

interface lsht_out_if #(parameter int SW = 9, parameter int EW = 9);
  logic          valid;
  logic          ready;
  logic [SW-1:0] slot_index;
  logic [2:0]    action;
  logic          overflow;
  logic          member_kept;
  logic [EW-1:0] defined_count;

  modport source (output valid, slot_index, action, overflow, member_kept, defined_count,
                  input ready);
  modport sink   (input valid, slot_index, action, overflow, member_kept, defined_count,
                  output ready);
endinterface

// ===== hw/rtl/lsht_ram.sv =====
// ----------------------------------------------------------------------------
// lsht_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lsht_queue.sv =====
// ----------------------------------------------------------------------------
// lsht_queue - short work queue between front and back
// Two-entry FIFO of classified items.
// ----------------------------------------------------------------------------
module lsht_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  lsht_pkg::work_t  push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lsht_pkg::work_t  pop_data
);

  localparam int PW = $clog2(lsht_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(lsht_pkg::QUEUE_DEPTH + 1);

  lsht_pkg::work_t entry_r [lsht_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(lsht_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/lsht_front.sv =====
// ----------------------------------------------------------------------------
// lsht_front - request intake and hashing
// Accepts items, canonicalises names, hashes and reduces to the home slot.
// ----------------------------------------------------------------------------
module lsht_front #(
  parameter int SYMBOL_CAPACITY = 501
) (
  input  logic              clk,
  input  logic              rst_n,
  lsht_in_if.sink           in_ch,
  input  lsht_pkg::status_t stat,
  output logic              push_valid,
  input  logic              push_ready,
  output lsht_pkg::work_t   push_data
);

  localparam int HW = lsht_pkg::HASH_W;
  localparam int RS = lsht_pkg::RECIP_SHIFT;
  localparam int PRW = HW + RS;
  localparam logic [RS-1:0] RECIP = RS'((64'd1 << RS) / SYMBOL_CAPACITY);
  localparam logic [HW-1:0] CAP_H = HW'(SYMBOL_CAPACITY);
  localparam int MW = HW + 12;

  logic            a_v_r;
  lsht_pkg::work_t a_item_r;
  logic [HW-1:0]   a_hash_r;
  logic [PRW-1:0]  a_prod_r;

  logic            accept, advance;
  logic [2:0]      kind_norm;
  logic [HW-1:0]   hash_in;
  logic [HW-1:0]   quot;
  logic [MW-1:0]   qmul;
  logic [HW-1:0]   rem0, rem1;

  assign advance     = !a_v_r || push_ready;
  assign in_ch.ready = stat.clear_done && advance;
  assign accept      = in_ch.valid && in_ch.ready;

  // Kind codes above KIND_BSS count as absolute.
  assign kind_norm = (in_ch.sym_kind > lsht_pkg::KIND_BSS) ? lsht_pkg::KIND_ABS
                                                             : in_ch.sym_kind;
  assign hash_in   = lsht_pkg::name_hash(in_ch.sym_name);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (advance) begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r.req_type   <= in_ch.req_type;
      a_item_r.key        <= lsht_pkg::canon_name(in_ch.sym_name);
      a_item_r.home       <= '0;
      a_item_r.kind       <= kind_norm;
      a_item_r.value      <= in_ch.sym_value;
      a_item_r.is_library <= in_ch.is_library;
      a_hash_r            <= hash_in;
      a_prod_r            <= PRW'(hash_in) * PRW'(RECIP);
    end
  end

  // Reciprocal estimate is low by at most one: one correction step.
  assign quot = a_prod_r[PRW-1:RS];
  assign qmul = MW'(quot) * MW'(SYMBOL_CAPACITY);
  assign rem0 = a_hash_r - qmul[HW-1:0];
  assign rem1 = (rem0 >= CAP_H) ? rem0 - CAP_H : rem0;

  always_comb begin
    push_data      = a_item_r;
    push_data.home = lsht_pkg::SLOT_W_MAX'(rem1) + lsht_pkg::SLOT_W_MAX'(2);
  end
  assign push_valid = a_v_r;

endmodule

// ===== hw/rtl/lsht_back.sv =====
// ----------------------------------------------------------------------------
// lsht_back - probe, insert, resolve and roll back
// Sequencer over the slot table, symbol store and insert stack memories.
// ----------------------------------------------------------------------------
module lsht_back #(
  parameter int SYMBOL_CAPACITY = 501
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lsht_pkg::work_t   pop_data,
  output lsht_pkg::status_t stat,
  lsht_out_if.source        out_ch
);

  localparam int SLOTS = SYMBOL_CAPACITY + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int EW    = $clog2(SYMBOL_CAPACITY + 1);
  localparam int SAW   = $clog2(SYMBOL_CAPACITY);
  localparam int SYW   = $bits(lsht_pkg::sym_entry_t);

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_PROBE    = 5'b00100,
    ST_CMP      = 5'b01000,
    ST_ROLLBACK = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  lsht_pkg::work_t   item_r, item_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [EW-1:0]     entry_r, entry_nxt;
  logic [EW-1:0]     count_r, count_nxt;
  logic [EW-1:0]     start_r, start_nxt;
  logic [EW-1:0]     defs_r, defs_nxt;
  logic [EW-1:0]     sp_r, sp_nxt;

  logic              out_v_r, out_v_nxt;
  logic [SW-1:0]     out_slot_r, out_slot_nxt;
  logic [2:0]        out_act_r, out_act_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_kept_r, out_kept_nxt;
  logic [EW-1:0]     out_defs_r, out_defs_nxt;

  logic              slot_we, slot_re;
  logic [SW-1:0]     slot_waddr, slot_raddr;
  logic [EW-1:0]     slot_wdata, slot_q;
  logic              sym_we, sym_re;
  logic [SAW-1:0]    sym_waddr, sym_raddr;
  lsht_pkg::sym_entry_t sym_wdata, sym_q;
  logic              stk_we, stk_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [SW-1:0]     stk_q;

  logic              fin_member, fin_kept, fin_sym, fin_ovf;
  lsht_pkg::action_t fin_act;
  logic [EW-1:0]     slot_m1, entry_m1, sp_m1;

  assign slot_m1  = slot_q - 1'b1;
  assign entry_m1 = entry_r - 1'b1;
  assign sp_m1    = sp_r - 1'b1;

  lsht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_q)
  );

  lsht_ram #(.WIDTH(SYW), .DEPTH(SYMBOL_CAPACITY)) u_sym_ram (
    .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
    .re(sym_re), .raddr(sym_raddr), .rdata(sym_q)
  );

  lsht_ram #(.WIDTH(SW), .DEPTH(SYMBOL_CAPACITY)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(slot_r),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_q)
  );

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    clr_nxt      = clr_r;
    slot_nxt     = slot_r;
    entry_nxt    = entry_r;
    count_nxt    = count_r;
    start_nxt    = start_r;
    defs_nxt     = defs_r;
    sp_nxt       = sp_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_slot_nxt = out_slot_r;
    out_act_nxt  = out_act_r;
    out_ovf_nxt  = out_ovf_r;
    out_kept_nxt = out_kept_r;
    out_defs_nxt = out_defs_r;

    pop_ready  = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = slot_r;
    sym_we     = 1'b0;
    sym_waddr  = entry_m1[SAW-1:0];
    sym_wdata  = '0;
    sym_re     = 1'b0;
    sym_raddr  = slot_m1[SAW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp_r[SAW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = sp_m1[SAW-1:0];

    fin_member = 1'b0;
    fin_kept   = 1'b0;
    fin_sym    = 1'b0;
    fin_ovf    = 1'b0;
    fin_act    = lsht_pkg::ACT_INSERTED;

    unique case (state_r)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        if (clr_r == SW'(SLOTS - 1)) state_nxt = ST_IDLE;
        else                         clr_nxt   = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (pop_valid && !out_v_r) begin
          pop_ready = 1'b1;
          item_nxt  = pop_data;
          if (pop_data.req_type == lsht_pkg::REQ_MEMBER_END) begin
            if (!pop_data.is_library || defs_r != '0) begin
              fin_member = 1'b1;
              fin_kept   = 1'b1;
            end else if (sp_r == '0) begin
              fin_member = 1'b1;
              count_nxt  = start_r;
            end else begin
              stk_re    = 1'b1;
              sp_nxt    = sp_m1;
              state_nxt = ST_ROLLBACK;
            end
          end else begin
            slot_nxt   = pop_data.home[SW-1:0];
            slot_re    = 1'b1;
            slot_raddr = pop_data.home[SW-1:0];
            state_nxt  = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (slot_q == '0) begin
          fin_sym   = 1'b1;
          state_nxt = ST_IDLE;
          if (count_r >= EW'(SYMBOL_CAPACITY)) begin
            fin_ovf = 1'b1;
          end else begin
            sym_we     = 1'b1;
            sym_waddr  = count_r[SAW-1:0];
            sym_wdata  = '{name: item_r.key, kind: item_r.kind, value: item_r.value};
            slot_we    = 1'b1;
            slot_wdata = count_r + 1'b1;
            stk_we     = 1'b1;
            sp_nxt     = sp_r + 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end else begin
          entry_nxt = slot_q;
          sym_re    = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sym_q.name == item_r.key) begin
          fin_sym   = 1'b1;
          state_nxt = ST_IDLE;
          if (sym_q.kind != lsht_pkg::KIND_UNDEF) begin
            fin_act = lsht_pkg::ACT_KEPT;
          end else if (item_r.kind == lsht_pkg::KIND_UNDEF) begin
            fin_act = lsht_pkg::ACT_COMMON;
            if (item_r.value > sym_q.value) begin
              sym_we    = 1'b1;
              sym_wdata = '{name: sym_q.name, kind: sym_q.kind, value: item_r.value};
            end
          end else if (sym_q.value != '0 && item_r.kind == lsht_pkg::KIND_TEXT) begin
            fin_act = lsht_pkg::ACT_TEXT_IGNORED;
          end else begin
            fin_act   = lsht_pkg::ACT_DEFINED;
            sym_we    = 1'b1;
            sym_wdata = '{name: sym_q.name, kind: item_r.kind, value: item_r.value};
            if (defs_r < EW'(SYMBOL_CAPACITY)) defs_nxt = defs_r + 1'b1;
          end
        end else begin
          // Step to the next slot, wrapping at the end of the table.
          slot_nxt   = (slot_r == SW'(SLOTS - 1)) ? '0 : slot_r + 1'b1;
          slot_re    = 1'b1;
          slot_raddr = slot_nxt;
          state_nxt  = ST_PROBE;
        end
      end
      ST_ROLLBACK: begin
        slot_we    = 1'b1;
        slot_waddr = stk_q;
        if (sp_r == '0) begin
          fin_member = 1'b1;
          count_nxt  = start_r;
          state_nxt  = ST_IDLE;
        end else begin
          stk_re = 1'b1;
          sp_nxt = sp_m1;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    if (fin_member) begin
      out_v_nxt    = 1'b1;
      out_slot_nxt = '0;
      out_act_nxt  = lsht_pkg::ACT_INSERTED;
      out_ovf_nxt  = 1'b0;
      out_kept_nxt = fin_kept;
      out_defs_nxt = defs_r;
      defs_nxt     = '0;
      sp_nxt       = '0;
      start_nxt    = count_nxt;
    end
    if (fin_sym) begin
      out_v_nxt    = 1'b1;
      out_slot_nxt = slot_r;
      out_act_nxt  = fin_act;
      out_ovf_nxt  = fin_ovf;
      out_kept_nxt = 1'b0;
      out_defs_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      start_r <= '0;
      defs_r  <= '0;
      sp_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
      defs_r  <= defs_nxt;
      sp_r    <= sp_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    entry_r    <= entry_nxt;
    out_slot_r <= out_slot_nxt;
    out_act_r  <= out_act_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_kept_r <= out_kept_nxt;
    out_defs_r <= out_defs_nxt;
  end

  assign stat.clear_done      = (state_r != ST_CLEAR);
  assign out_ch.valid         = out_v_r;
  assign out_ch.slot_index    = out_slot_r;
  assign out_ch.action        = out_act_r;
  assign out_ch.overflow      = out_ovf_r;
  assign out_ch.member_kept   = out_kept_r;
  assign out_ch.defined_count = out_defs_r;

endmodule

// ===== hw/rtl/linker_symbol_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linker_symbol_hash_table_top - external symbol resolver
// Hashed slot table with linear probing, symbol store and member rollback.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+---------------------------------------------------
//  in_ch    | in        | symbol item or member end (name, kind, value, lib)
//  out_ch   | out       | slot, action, overflow, member kept, definitions
//
//  Front: one register stage; hash at intake, reduce in the next cycle,
//  one item per cycle while the queue has room.
//  Back: a symbol item reads its home slot, then for each occupied slot holding
//  another name compares it and steps on, until an empty slot or the name is found.
//  Member end: a rolled-back member clears its inserted slots from the insert stack.
//  After reset the SYMBOL_CAPACITY + 2 slots (503 by default) of the slot table
//  are cleared, one slot a cycle; no item is taken until then.
//  A two-entry queue parts front and back; results wait in an output register.
// ----------------------------------------------------------------------------
module linker_symbol_hash_table_top #(
  parameter int SYMBOL_CAPACITY = 501
) (
  input  logic       clk,
  input  logic       rst_n,
  lsht_in_if.sink    in_ch,
  lsht_out_if.source out_ch
);

  lsht_pkg::status_t stat;
  logic              push_valid, push_ready;
  lsht_pkg::work_t   push_data;
  logic              pop_valid, pop_ready;
  lsht_pkg::work_t   pop_data;

  lsht_front #(.SYMBOL_CAPACITY(SYMBOL_CAPACITY)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .stat(stat),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  lsht_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  lsht_back #(.SYMBOL_CAPACITY(SYMBOL_CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .stat(stat), .out_ch(out_ch)
  );

endmodule

// ===== sim/tb_linker_symbol_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_linker_symbol_hash_table_top - testbench of the external symbol resolver
// Sends symbol and member-end items with random gaps and output stalls,
// predicts every result with an own model of the slot table and symbol store,
// and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_linker_symbol_hash_table_top;

  localparam int CAPACITY  = 501;
  localparam int SLOTS     = CAPACITY + 2;
  localparam int MAX_IDLE  = 17;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [8:0]          slot_index;
    lsht_pkg::action_t   action;
    logic                overflow;
    logic                member_kept;
    logic [8:0]          defined_count;
  } resolution_t;

  logic clk = 1'b0;
  logic rst_n;

  lsht_in_if             in_ch();
  lsht_out_if #(9, 9)    out_ch();

  linker_symbol_hash_table_top #(.SYMBOL_CAPACITY(CAPACITY)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Own copy of the resolver state
  int unsigned   slot_map [SLOTS];     // 0 empty, else store index + 1
  logic [63:0]   sym_names [CAPACITY];
  logic [2:0]    sym_kinds [CAPACITY];
  logic [15:0]   sym_values [CAPACITY];
  int unsigned   sym_count;
  int unsigned   member_base;
  int unsigned   member_defs;
  int unsigned   inserted_slots [$];

  resolution_t   pending_results [$];
  logic [63:0]   name_pool [64];
  int            src_idle_max;
  int            sink_idle_max;
  int            sink_wait;
  int            errors;
  longint        cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] name_key(input logic [63:0] raw);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] == 8'd0) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic int unsigned home_of(input logic [63:0] raw);
    int unsigned h;
    byte         b;
    h = 0;
    for (int i = 0; i < 8; i++) begin
      b = byte'(raw[8*i +: 8]);
      h = (h << 1) + int'(b);
    end
    return (h & 32'h7FFF) % CAPACITY + 2;
  endfunction

  task automatic resolve(input logic req, input logic [63:0] raw, input logic [2:0] kind_in,
                         input logic [15:0] value, input logic lib);
    resolution_t r;
    logic [63:0] key;
    logic [2:0]  kind;
    int unsigned s;
    int unsigned ix;
    r = '{slot_index: '0, action: lsht_pkg::ACT_INSERTED, overflow: 1'b0,
          member_kept: 1'b0, defined_count: '0};
    if (req == lsht_pkg::REQ_MEMBER_END) begin
      if (!lib || member_defs != 0) begin
        r.member_kept = 1'b1;
      end else begin
        // drop this member's inserts
        foreach (inserted_slots[i]) slot_map[inserted_slots[i]] = 0;
        sym_count = member_base;
      end
      r.defined_count = member_defs[8:0];
      member_defs = 0;
      inserted_slots.delete();
      member_base = sym_count;
    end else begin
      key  = name_key(raw);
      kind = (kind_in > 3'd4) ? lsht_pkg::KIND_ABS : kind_in;
      s    = home_of(raw);
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_map[s] == 0 || sym_names[slot_map[s] - 1] == key) break;
        s = (s + 1 >= SLOTS) ? 0 : s + 1;
      end
      r.slot_index = s[8:0];
      if (slot_map[s] == 0) begin
        if (sym_count >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          sym_names[sym_count]  = key;
          sym_kinds[sym_count]  = kind;
          sym_values[sym_count] = value;
          sym_count++;
          slot_map[s] = sym_count;
          inserted_slots.push_back(s);
        end
      end else begin
        ix = slot_map[s] - 1;
        if (sym_kinds[ix] != lsht_pkg::KIND_UNDEF) begin
          r.action = lsht_pkg::ACT_KEPT;
        end else if (kind == lsht_pkg::KIND_UNDEF) begin
          if (value > sym_values[ix]) sym_values[ix] = value;
          r.action = lsht_pkg::ACT_COMMON;
        end else if (sym_values[ix] != 0 && kind == lsht_pkg::KIND_TEXT) begin
          r.action = lsht_pkg::ACT_TEXT_IGNORED;
        end else begin
          if (member_defs < CAPACITY) member_defs++;
          sym_kinds[ix]  = kind;
          sym_values[ix] = value;
          r.action = lsht_pkg::ACT_DEFINED;
        end
      end
    end
    pending_results.push_back(r);
  endtask

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(input logic req, input logic [63:0] raw, input logic [2:0] kind,
                           input logic [15:0] value, input logic lib);
    int gap;
    gap = (src_idle_max > 0) ? $urandom_range(0, src_idle_max) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.sym_name   <= raw;
    in_ch.sym_kind   <= kind;
    in_ch.sym_value  <= value;
    in_ch.is_library <= lib;
    do @(posedge clk); while (!in_ch.ready);
    resolve(req, raw, kind, value, lib);
  endtask

  task automatic end_member(input logic lib);
    send_item(lsht_pkg::REQ_MEMBER_END, {$urandom, $urandom}, 3'($urandom),
              16'($urandom), lib);
  endtask

  task automatic test_directed();
    // first character in the low byte
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", lsht_pkg::KIND_UNDEF, 16'd10, 1'b1);
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", lsht_pkg::KIND_UNDEF, 16'd40, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", lsht_pkg::KIND_UNDEF, 16'd5, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", lsht_pkg::KIND_TEXT, 16'd7, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", 3'd3, 16'hFFFF, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, "\0\0\0\0\0\0ba", lsht_pkg::KIND_ABS, 16'd1, 1'b0);
    // text over a zero-size common defines it
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0000_0063, lsht_pkg::KIND_UNDEF, 16'd0,
              1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0000_0063, lsht_pkg::KIND_TEXT, 16'd3,
              1'b0);
    // bytes after a zero byte: same key, other hash
    send_item(lsht_pkg::REQ_SYMBOL, 64'h7A79_7800_0000_0064, lsht_pkg::KIND_UNDEF, 16'd2,
              1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0000_0064, lsht_pkg::KIND_BSS, 16'd9,
              1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 16'hFFFF, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h8080_8080_8080_8080, 3'd5, 16'd0, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0, lsht_pkg::KIND_UNDEF, 16'hFFFF, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0, 3'd6, 16'd1, 1'b0);
    end_member(1'b0);
    // library member without definitions is rolled back
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0065_6565, lsht_pkg::KIND_UNDEF, 16'd4,
              1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0066_6666, lsht_pkg::KIND_ABS, 16'd4,
              1'b0);
    end_member(1'b1);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0065_6565, lsht_pkg::KIND_TEXT, 16'd8,
              1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, 64'h0000_0000_0000_0063, lsht_pkg::KIND_UNDEF, 16'd1,
              1'b0);
    end_member(1'b1);
    end_member(1'b1);
  endtask

  task automatic test_random(input int count);
    logic [63:0] raw;
    logic [2:0]  kind;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        // each stretch draws at random whether source and sink idle
        src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
        sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      end
      if ($urandom_range(0, 11) == 0) begin
        end_member(1'($urandom_range(0, 1)));
      end else begin
        raw  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                           : name_pool[$urandom_range(0, 63)];
        kind = ($urandom_range(0, 2) == 0) ? 3'($urandom) : lsht_pkg::KIND_UNDEF;
        send_item(lsht_pkg::REQ_SYMBOL, raw, kind,
                  ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      end
    end
    end_member(1'b0);
  endtask

  task automatic test_store_full();
    logic [63:0] raw;
    int          n;
    src_idle_max  = 2;
    sink_idle_max = 2;
    n = 0;
    while (sym_count < CAPACITY + 6 && n < 900) begin
      raw = {32'h5453_5251, 8'(n % 250 + 1), 8'(n / 250 + 1), 16'h4141};
      send_item(lsht_pkg::REQ_SYMBOL, raw, lsht_pkg::KIND_UNDEF, 16'(n), 1'b0);
      n++;
      if (sym_count >= CAPACITY) break;
    end
    for (int i = 0; i < 6; i++)
      send_item(lsht_pkg::REQ_SYMBOL, {32'h4F56_4552, 8'(i + 1), 24'h46_4C4F},
                lsht_pkg::KIND_ABS, 16'd1, 1'b0);
    send_item(lsht_pkg::REQ_SYMBOL, name_pool[0], lsht_pkg::KIND_UNDEF, 16'd3, 1'b0);
    end_member(1'b1);
    send_item(lsht_pkg::REQ_SYMBOL, {32'h4F56_4552, 32'h0146_4C4F}, lsht_pkg::KIND_ABS,
              16'd2, 1'b0);
    end_member(1'b0);
  endtask

  // Result side: random stalls, compare each taken item with the oldest prediction
  always @(posedge clk) begin
    resolution_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.slot_index !== exp_r.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_r.slot_index, out_ch.slot_index);
          errors++;
        end
        if (out_ch.action !== exp_r.action) begin
          $error("action: expected %0d, got %0d", exp_r.action, out_ch.action);
          errors++;
        end
        if (out_ch.overflow !== exp_r.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_r.overflow, out_ch.overflow);
          errors++;
        end
        if (out_ch.member_kept !== exp_r.member_kept) begin
          $error("member_kept: expected %0b, got %0b", exp_r.member_kept, out_ch.member_kept);
          errors++;
        end
        if (out_ch.defined_count !== exp_r.defined_count) begin
          $error("defined_count: expected %0d, got %0d", exp_r.defined_count,
                 out_ch.defined_count);
          errors++;
        end
      end
      sink_wait = (sink_idle_max > 0) ? $urandom_range(0, sink_idle_max) : 0;
    end
    if (sink_wait > 0) begin
      out_ch.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = lsht_pkg::REQ_SYMBOL;
    in_ch.sym_name = '0;
    in_ch.sym_kind = '0;
    in_ch.sym_value = '0;
    in_ch.is_library = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    sink_wait = 0;
    src_idle_max = MAX_IDLE;
    sink_idle_max = MAX_IDLE;
    sym_count = 0;
    member_base = 0;
    member_defs = 0;
    foreach (slot_map[i]) slot_map[i] = 0;
    foreach (name_pool[i]) begin
      name_pool[i] = {$urandom, $urandom};
      // mostly names of at most six 7-bit bytes, some with a zero byte inside
      if (i % 3 != 0) name_pool[i] = name_pool[i] & 64'h0000_7F7F_7F7F_7F7F | 64'h0101_0101;
      if (i % 7 == 0) name_pool[i][23:16] = 8'd0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(700);
    test_store_full();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lsht_pkg.sv
hw/rtl/lsht_if.sv
hw/rtl/lsht_ram.sv
hw/rtl/lsht_queue.sv
hw/rtl/lsht_front.sv
hw/rtl/lsht_back.sv
hw/rtl/linker_symbol_hash_table_top.sv
sim/tb_linker_symbol_hash_table_top.sv
